// ===== rtl/core/eight_neighbour_mean_smoother_unit_assert.svh =====
// Assertion helpers for the smoother RTL.
`ifndef EIGHT_NEIGHBOUR_MEAN_SMOOTHER_UNIT_ASSERT_SVH
`define EIGHT_NEIGHBOUR_MEAN_SMOOTHER_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define ENS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define ENS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ens_pkg.sv =====
package ens_pkg;

    localparam int FW_W     = 12;
    localparam int FH_W     = 16;
    localparam int PIX_W    = 24;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PW    = $clog2(OQ_DEPTH);
    localparam int OQ_UW    = $clog2(OQ_DEPTH + 1);

    // Register index, taken from paddr[2]
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    // Input word codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef logic [PIX_W-1:0] t_rgb;

    typedef struct packed {
        logic       cmd;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       end_of_frame;
        logic       last_of_item;
    } t_pix_out;

    // Control carried from the accept stage through the line-store read
    typedef struct packed {
        logic pix_act;
        logic flush_act;
        logic has0;
        logic has1;
        logic border;
        logic eof;
        t_rgb pix;
    } t_s1_ctrl;

    // Up to two words pushed into the output queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_pix_out   w0;
        t_pix_out   w1;
    } t_push;

endpackage

// ===== rtl/core/ens_stream_if.sv =====
interface ens_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ens_ram.sv =====
module ens_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ===== rtl/core/ens_window.sv =====
module ens_window
    import ens_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_s1_ctrl i_s1,
    input  t_rgb     i_rd_older,
    input  t_rgb     i_rd_newer,
    output t_push    o_push
);
    // r_win[row][col]: row 0 older line, row 1 newer line, row 2 incoming; col 2 newest
    t_rgb     r_win [3][3];
    t_s1_ctrl r_s2;
    t_s1_ctrl n_s2;
    t_rgb     smooth;
    t_rgb     first_pix;

    always_ff @(posedge i_clk) begin
        if (i_s1.pix_act) begin
            for (int a = 0; a < 3; a++) begin
                r_win[a][0] <= r_win[a][1];
                r_win[a][1] <= r_win[a][2];
            end
            r_win[0][2] <= i_rd_older;
            r_win[1][2] <= i_rd_newer;
            r_win[2][2] <= i_s1.pix;
        end
    end

    // Stage 2 control; the flush pixel rides in the pix field
    always_comb begin
        n_s2     = i_s1;
        n_s2.pix = i_rd_newer;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    always_comb begin : p_smooth
        logic [10:0] sum;
        for (int ch = 0; ch < 3; ch++) begin
            sum = '0;
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    if (a != 1 || b != 1) begin
                        sum = sum + 11'(r_win[a][b][ch*8 +: 8]);
                    end
                end
            end
            smooth[ch*8 +: 8] = sum[10:3];
        end
    end

    function automatic t_pix_out mk_word(input t_rgb pix, input logic eof,
                                         input logic last);
        t_pix_out w;
        w.out_red      = pix[23:16];
        w.out_green    = pix[15:8];
        w.out_blue     = pix[7:0];
        w.end_of_frame = eof;
        w.last_of_item = last;
        return w;
    endfunction

    assign first_pix = r_s2.border ? r_win[1][1] : smooth;

    always_comb begin
        o_push.cnt = 2'd0;
        o_push.w0  = mk_word(r_win[1][2], 1'b0, 1'b1);
        o_push.w1  = mk_word(r_win[1][2], 1'b0, 1'b1);
        if (r_s2.flush_act) begin
            o_push.cnt = 2'd1;
            o_push.w0  = mk_word(r_s2.pix, r_s2.eof, 1'b1);
        end else if (r_s2.pix_act) begin
            if (r_s2.has0 && r_s2.has1) begin
                o_push.cnt = 2'd2;
                o_push.w0  = mk_word(first_pix, 1'b0, 1'b0);
            end else if (r_s2.has0) begin
                o_push.cnt = 2'd1;
                o_push.w0  = mk_word(first_pix, 1'b0, 1'b1);
            end else if (r_s2.has1) begin
                // right border word only
                o_push.cnt = 2'd1;
            end
        end
    end
endmodule

// ===== rtl/core/ens_outq.sv =====
module ens_outq
    import ens_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_push             i_push,
    ens_stream_if.source      o_res,
    output logic [OQ_UW-1:0]  o_count
);
    t_pix_out          r_mem [OQ_DEPTH];
    logic [OQ_PW-1:0]  r_wptr;
    logic [OQ_PW-1:0]  r_rptr;
    logic [OQ_UW-1:0]  r_count;
    logic [OQ_PW-1:0]  wptr_next1;
    logic              pop;

    assign wptr_next1  = r_wptr + OQ_PW'(1);
    assign pop         = o_res.valid & o_res.ready;
    assign o_res.valid = (r_count != '0);
    assign o_res.data  = r_mem[r_rptr];
    assign o_count     = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wptr] <= i_push.w0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wptr_next1] <= i_push.w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + OQ_PW'(i_push.cnt);
            if (pop) begin
                r_rptr <= r_rptr + OQ_PW'(1);
            end
            r_count <= r_count + OQ_UW'(i_push.cnt) - OQ_UW'(pop);
        end
    end
endmodule

// ===== rtl/core/eight_neighbour_mean_smoother_unit.sv =====
// 3x3 eight-neighbor mean smoother for a raster RGB stream. Each input word is a pixel
// (cmd 0) or a flush tick (cmd 1); output lags one row, border pixels pass unchanged,
// and after the last pixel of a frame one flush word per column drains the final row.
// Throughput is one input word per clock while the output queue has room: the two
// line stores share one 48-bit wide single-port-read RAM, read when a word is taken
// and written back in the next cycle, with a one-deep bypass for back-to-back hits
// on the same column. A word's results are registered in r_s1 and r_s2, then queued.
// The 8-entry output queue stops input when 7 or more results are queued or in flight;
// a row-end pixel can give two results, so a stalled consumer backs up input after
// four to seven words that carry results. No clearing pass follows reset.
// frame_width and frame_height sit at byte offsets 0x0 and 0x4.
`include "eight_neighbour_mean_smoother_unit_assert.svh"
module eight_neighbour_mean_smoother_unit
    import ens_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    ens_stream_if.sink        i_pix,
    ens_stream_if.source      o_res
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int EXW = ((CW > FW_W) ? CW : FW_W) + 1;

    logic [FW_W-1:0]    r_frame_width;
    logic [FH_W-1:0]    r_frame_height;
    logic [CW-1:0]      r_col;
    logic [FH_W-1:0]    r_row;
    logic               r_frame_rcvd;
    logic [OQ_UW-1:0]   r_used;
    t_s1_ctrl           r_s1;
    logic [CW-1:0]      r_s1_addr;
    logic               r_fwd_hit;
    logic [2*PIX_W-1:0] r_fwd_data;

    t_s1_ctrl           n_s1;
    logic               cfg_wr;
    logic [CW-1:0]      wm1;
    logic [FH_W-1:0]    hm1;
    logic               accept;
    logic               pop;
    logic               pix_act;
    logic               flush_act;
    logic               row_end;
    logic               row_started;
    logic               has0;
    logic               has1;
    logic               border;
    logic [1:0]         n_res;
    logic               rd_en;
    logic [2*PIX_W-1:0] ram_q;
    logic [2*PIX_W-1:0] rd_word;
    logic [2*PIX_W-1:0] wr_data;
    t_push              push;
    logic [OQ_UW-1:0]   oq_count;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(2048);
            r_frame_height <= FH_W'(1);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_IDX_WIDTH:  r_frame_width  <= pwdata[FW_W-1:0];
                REG_IDX_HEIGHT: r_frame_height <= pwdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IDX_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_IDX_HEIGHT: prdata = APB_DW'(r_frame_height);
            default:        prdata = '0;
        endcase
    end

    // last column and last row indices after clamping
    always_comb begin
        if (r_frame_width == '0) begin
            wm1 = '0;
        end else if (EXW'(r_frame_width) > EXW'(MAX_WIDTH)) begin
            wm1 = CW'(MAX_WIDTH - 1);
        end else begin
            wm1 = CW'(EXW'(r_frame_width) - EXW'(1));
        end
        hm1 = (r_frame_height == '0) ? '0 : (r_frame_height - FH_W'(1));
    end

    // accept stage: all control is decided from the counters, the frame flag and the cmd bit
    assign i_pix.ready = (r_used <= OQ_UW'(OQ_DEPTH - 2));
    assign accept      = i_pix.valid & i_pix.ready;
    assign pop         = o_res.valid & o_res.ready;

    assign pix_act     = (i_pix.data.cmd == CMD_PIXEL) & ~r_frame_rcvd;
    assign flush_act   = (i_pix.data.cmd == CMD_FLUSH) & r_frame_rcvd;
    assign row_end     = (r_col >= wm1);
    assign row_started = (r_row != '0);
    assign has0        = pix_act & row_started & (r_col != '0);
    assign has1        = pix_act & row_started & row_end;
    assign border      = (r_row == FH_W'(1)) || ((r_row - FH_W'(1)) >= hm1)
                       || (r_col == CW'(1)) || ((r_col - CW'(1)) >= wm1);
    assign n_res       = flush_act ? 2'd1 : (2'(has0) + 2'(has1));

    always_comb begin
        n_s1.pix_act   = accept & pix_act;
        n_s1.flush_act = accept & flush_act;
        n_s1.has0      = has0;
        n_s1.has1      = has1;
        n_s1.border    = border;
        n_s1.eof       = row_end;
        n_s1.pix       = {i_pix.data.in_red, i_pix.data.in_green, i_pix.data.in_blue};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_frame_rcvd <= 1'b0;
            r_used       <= '0;
            r_s1         <= '0;
            r_fwd_hit    <= 1'b0;
        end else begin
            r_s1      <= n_s1;
            r_fwd_hit <= rd_en & r_s1.pix_act & (r_s1_addr == r_col);
            r_used    <= r_used + OQ_UW'(accept ? n_res : 2'd0) - OQ_UW'(pop);
            if (accept && flush_act) begin
                if (row_end) begin
                    r_col        <= '0;
                    r_row        <= '0;
                    r_frame_rcvd <= 1'b0;
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end else if (accept && pix_act) begin
                if (row_end) begin
                    r_col <= '0;
                    if (r_row >= hm1) begin
                        r_frame_rcvd <= 1'b1;
                    end else begin
                        r_row <= r_row + FH_W'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr  <= r_col;
        r_fwd_data <= wr_data;
    end

    // line stores: {older, newer} per column; read on accept, written back next cycle
    assign rd_en   = accept & (pix_act | flush_act);
    assign rd_word = r_fwd_hit ? r_fwd_data : ram_q;
    assign wr_data = {rd_word[PIX_W-1:0], r_s1.pix};

    ens_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1.pix_act),
        .i_waddr (r_s1_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (r_col),
        .o_rdata (ram_q)
    );

    ens_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1       (r_s1),
        .i_rd_older (rd_word[2*PIX_W-1:PIX_W]),
        .i_rd_newer (rd_word[PIX_W-1:0]),
        .o_push     (push)
    );

    ens_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_res   (o_res),
        .o_count (oq_count)
    );

    `ENS_ASSERT_IMPLY(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= OQ_UW'(OQ_DEPTH), "reservation count overran the output queue")
    `ENS_ASSERT_IMPLY(a_queue_reserved, i_clk, i_rst_n, 1'b1, oq_count <= r_used, "queued words exceed reserved slots")
    `ENS_ASSERT_NEXT(a_stray_flush, i_clk, i_rst_n, accept && (i_pix.data.cmd == CMD_FLUSH) && !r_frame_rcvd, !r_s1.flush_act && !r_s1.pix_act, "early flush started line-store work")
    `ENS_ASSERT_IMPLY(a_fwd_source, i_clk, i_rst_n, r_fwd_hit, $past(r_s1.pix_act), "bypass hit without a write-back")
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import ens_pkg::*;

    localparam int   MAX_W        = 2048;
    localparam int   IDLE_PCT     = 9;
    localparam int   NOISE_PCT    = 8;
    localparam int   DRAIN_CYCLES = 16;
    localparam int   HOLD_CYCLES  = 400;
    localparam int   RAND_ITEMS   = 1100;
    localparam int   MAX_REPORTS  = 100;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    ens_stream_if #(.T(t_pix_in))  pix_if ();
    ens_stream_if #(.T(t_pix_out)) res_if ();

    eight_neighbour_mean_smoother_unit #(.MAX_WIDTH(MAX_W)) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_if),
        .o_res   (res_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stimulus and expected output words
    t_pix_in     pixel_feed[$];
    t_pix_out    smoothed_due[$];
    int          idle_pct = IDLE_PCT;
    int          mismatches = 0;
    int unsigned hold_reqs = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    logic        pix_taken = 1'b0;

    // Shadow of the smoother state
    t_rgb        older_row [MAX_W];
    t_rgb        newer_row [MAX_W];
    t_rgb        win [3][3];
    int unsigned rows_seen;
    int unsigned col_pos;
    int unsigned flush_pos;
    bit          frame_in;
    logic [11:0] cfg_w;
    logic [15:0] cfg_h;

    function automatic int unsigned eff_w();
        if (cfg_w == 0) return 1;
        if (cfg_w > MAX_W) return MAX_W;
        return cfg_w;
    endfunction

    function automatic int unsigned eff_h();
        return (cfg_h == 0) ? 1 : cfg_h;
    endfunction

    function automatic t_rgb neighbour_mean();
        t_rgb        res;
        int unsigned sum;
        for (int ch = 0; ch < 3; ch++) begin
            sum = 0;
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    if (a != 1 || b != 1) begin
                        sum += win[a][b][ch*8 +: 8];
                    end
                end
            end
            res[ch*8 +: 8] = 8'(sum >> 3);
        end
        return res;
    endfunction

    function automatic t_pix_out make_word(t_rgb pix, logic eof);
        t_pix_out o;
        o.out_red      = pix[23:16];
        o.out_green    = pix[15:8];
        o.out_blue     = pix[7:0];
        o.end_of_frame = eof;
        o.last_of_item = 1'b0;
        return o;
    endfunction

    task automatic advance_smoother(t_pix_in it);
        int unsigned w;
        int unsigned h;
        int unsigned j;
        int unsigned f;
        int unsigned r;
        int unsigned c;
        int          n;
        t_pix_out    outs [2];
        t_rgb        pix;
        bit          row_end;
        bit          rim_row;
        bit          rim;
        w = eff_w();
        h = eff_h();
        n = 0;
        if (it.cmd == CMD_FLUSH) begin
            if (frame_in) begin
                f = (flush_pos >= MAX_W) ? MAX_W - 1 : flush_pos;
                outs[0] = make_word(newer_row[f], f >= w - 1);
                n = 1;
                if (f >= w - 1) begin
                    rows_seen = 0;
                    col_pos   = 0;
                    flush_pos = 0;
                    frame_in  = 1'b0;
                end else begin
                    flush_pos = f + 1;
                end
            end
        end else if (!frame_in) begin
            j = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
            pix = {it.in_red, it.in_green, it.in_blue};
            row_end = (j >= w - 1);
            for (int a = 0; a < 3; a++) begin
                win[a][0] = win[a][1];
                win[a][1] = win[a][2];
            end
            win[0][2] = older_row[j];
            win[1][2] = newer_row[j];
            win[2][2] = pix;
            older_row[j] = newer_row[j];
            newer_row[j] = pix;
            if (rows_seen >= 1) begin
                r = rows_seen - 1;
                rim_row = (r == 0) || (r >= h - 1);
                if (j >= 1) begin
                    c = j - 1;
                    rim = rim_row || c == 0 || c >= w - 1;
                    outs[n] = make_word(rim ? win[1][1] : neighbour_mean(), 1'b0);
                    n++;
                end
                if (row_end) begin
                    outs[n] = make_word(win[1][2], 1'b0);
                    n++;
                end
            end
            if (row_end) begin
                col_pos = 0;
                if (rows_seen >= h - 1) begin
                    frame_in  = 1'b1;
                    flush_pos = 0;
                end else begin
                    rows_seen = (rows_seen + 1) & 16'hFFFF;
                end
            end else begin
                col_pos = j + 1;
            end
        end
        if (n > 0) begin
            outs[n-1].last_of_item = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            smoothed_due.push_back(outs[k]);
        end
    endtask

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        end
    endtask

    // Present the next word once the current one is taken
    always @(negedge clk) begin : pix_driver
        logic    next_valid;
        t_pix_in next_word;
        next_valid = pix_if.valid;
        next_word  = pix_if.data;
        if (!pix_if.valid || pix_taken) begin
            next_valid = 1'b0;
            if (pixel_feed.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_word  = pixel_feed.pop_front();
                next_valid = 1'b1;
            end
        end
        pix_if.valid <= next_valid;
        pix_if.data  <= next_word;
    end

    always @(negedge clk) begin : res_sink
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk) begin : word_monitor
        t_pix_out got;
        t_pix_out want;
        pix_taken <= pix_if.valid && pix_if.ready;
        if (rst_n && pix_if.valid && pix_if.ready) begin
            advance_smoother(pix_if.data);
        end
        if (rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (smoothed_due.size() == 0) begin
                flag_mismatch("word with nothing due", 32'(got), 0);
            end else begin
                want = smoothed_due.pop_front();
                if (got.out_red !== want.out_red)
                    flag_mismatch("out_red", 32'(got.out_red), 32'(want.out_red));
                if (got.out_green !== want.out_green)
                    flag_mismatch("out_green", 32'(got.out_green), 32'(want.out_green));
                if (got.out_blue !== want.out_blue)
                    flag_mismatch("out_blue", 32'(got.out_blue), 32'(want.out_blue));
                if (got.end_of_frame !== want.end_of_frame)
                    flag_mismatch("end_of_frame", 32'(got.end_of_frame),
                                  32'(want.end_of_frame));
                if (got.last_of_item !== want.last_of_item)
                    flag_mismatch("last_of_item", 32'(got.last_of_item),
                                  32'(want.last_of_item));
            end
        end
    end

    task automatic write_reg(logic idx, logic [APB_DW-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_IDX_WIDTH) begin
            cfg_w = val[11:0];
        end else begin
            cfg_h = val[15:0];
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [7:0] rand_byte();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [11:0] pick_width();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 6) return 12'd0;
        if (pick < 14) return 12'($urandom_range(11, 48));
        return 12'($urandom_range(1, 10));
    endfunction

    function automatic logic [15:0] pick_height();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 6) return 16'd0;
        if (pick < 10) return 16'($urandom_range(7, 12));
        return 16'($urandom_range(1, 6));
    endfunction

    task automatic queue_word(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_pix_in wd;
        wd.cmd      = cmd;
        wd.in_red   = r;
        wd.in_green = g;
        wd.in_blue  = b;
        pixel_feed.push_back(wd);
    endtask

    // One frame of random pixels and its flushes, with stray words mixed in
    task automatic push_frame(int unsigned w, int unsigned h, int noise);
        for (int unsigned p = 0; p < w * h; p++) begin
            if ($urandom_range(99) < noise) begin
                queue_word(CMD_FLUSH, rand_byte(), rand_byte(), rand_byte());
            end
            queue_word(CMD_PIXEL, rand_byte(), rand_byte(), rand_byte());
        end
        for (int unsigned k = 0; k < w; k++) begin
            if ($urandom_range(99) < noise) begin
                queue_word(CMD_PIXEL, rand_byte(), rand_byte(), rand_byte());
            end
            queue_word(CMD_FLUSH, rand_byte(), rand_byte(), rand_byte());
        end
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (pixel_feed.size() != 0 || pix_if.valid || smoothed_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Feed whatever the current frame still needs, under the current settings
    task automatic finish_frame();
        int unsigned w;
        int unsigned h;
        int unsigned left;
        logic        cmd;
        while (rows_seen != 0 || col_pos != 0 || frame_in) begin
            w = eff_w();
            h = eff_h();
            if (frame_in) begin
                cmd  = CMD_FLUSH;
                left = (flush_pos >= w - 1) ? 1 : w - flush_pos;
            end else begin
                cmd  = CMD_PIXEL;
                left = (col_pos >= w - 1) ? 1 : w - col_pos;
                if (rows_seen < h - 1) begin
                    left += (h - 1 - rows_seen) * w;
                end
            end
            repeat (left) queue_word(cmd, rand_byte(), rand_byte(), rand_byte());
            wait_idle();
        end
    endtask

    initial begin
        int unsigned fed;
        int unsigned phase;
        int unsigned cut;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        res_if.ready = 1'b0;
        cfg_w        = 12'd2048;
        cfg_h        = 16'd1;
        rows_seen    = 0;
        col_pos      = 0;
        flush_pos    = 0;
        frame_in     = 1'b0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                win[a][b] = '0;
            end
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // flush with no frame pending: dropped
        queue_word(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF);
        wait_idle();

        // zero width and height act as one; second pixel lands after frame end
        write_reg(REG_IDX_WIDTH, 0);
        write_reg(REG_IDX_HEIGHT, 0);
        queue_word(CMD_PIXEL, 8'hFF, 8'h00, 8'hFF);
        queue_word(CMD_PIXEL, 8'h00, 8'hFF, 8'h00);
        queue_word(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
        wait_idle();

        // 3x3 with saturated neighbors around an opposite center
        write_reg(REG_IDX_WIDTH, 3);
        write_reg(REG_IDX_HEIGHT, 3);
        for (int k = 0; k < 9; k++) begin
            queue_word(CMD_PIXEL, (k == 4) ? 8'h00 : 8'hFF, 8'(k), (k == 4) ? 8'hFF : 8'h00);
        end
        repeat (3) queue_word(CMD_FLUSH, rand_byte(), rand_byte(), rand_byte());
        wait_idle();

        write_reg(REG_IDX_WIDTH, 2);
        write_reg(REG_IDX_HEIGHT, 2);
        push_frame(2, 2, 0);
        wait_idle();

        fed = 0;
        phase = 0;
        while (fed < RAND_ITEMS) begin
            phase++;
            case (phase)
                3: begin
                    // no idling on either side
                    idle_pct = 0;
                    write_reg(REG_IDX_WIDTH, 12);
                    write_reg(REG_IDX_HEIGHT, 5);
                    push_frame(12, 5, 0);
                    wait_idle();
                    idle_pct = IDLE_PCT;
                    fed += 72;
                end
                6: begin
                    // stall the output long enough to back up the input
                    write_reg(REG_IDX_WIDTH, 16);
                    write_reg(REG_IDX_HEIGHT, 4);
                    hold_reqs++;
                    push_frame(16, 4, 0);
                    wait_idle();
                    fed += 80;
                end
                9: begin
                    // oversized width clamps to the full line store; narrow it to end the row
                    write_reg(REG_IDX_WIDTH, 32'h805);
                    write_reg(REG_IDX_HEIGHT, 1);
                    repeat (40) queue_word(CMD_PIXEL, rand_byte(), rand_byte(), rand_byte());
                    wait_idle();
                    write_reg(REG_IDX_WIDTH, 8);
                    finish_frame();
                    fed += 49;
                end
                12: begin
                    // tallest frame, cut short by lowering the height mid-frame
                    write_reg(REG_IDX_WIDTH, 3);
                    write_reg(REG_IDX_HEIGHT, 32'hFFFF);
                    repeat (12) queue_word(CMD_PIXEL, rand_byte(), rand_byte(), rand_byte());
                    wait_idle();
                    write_reg(REG_IDX_HEIGHT, 2);
                    finish_frame();
                    fed += 18;
                end
                default: begin
                    if ($urandom_range(1)) write_reg(REG_IDX_WIDTH, 32'(pick_width()));
                    if ($urandom_range(1)) write_reg(REG_IDX_HEIGHT, 32'(pick_height()));
                    if ($urandom_range(4) == 0) begin
                        cut = $urandom_range(1, eff_w() * eff_h());
                        queue_word(CMD_FLUSH, rand_byte(), rand_byte(), rand_byte());
                        repeat (cut) queue_word(CMD_PIXEL, rand_byte(), rand_byte(), rand_byte());
                        wait_idle();
                        // never widen mid-frame: the line stores would be read unwritten
                        write_reg(REG_IDX_WIDTH, $urandom_range(0, eff_w()));
                        if ($urandom_range(1)) write_reg(REG_IDX_HEIGHT, 32'(pick_height()));
                        finish_frame();
                    end else begin
                        push_frame(eff_w(), eff_h(), NOISE_PCT);
                        wait_idle();
                    end
                    fed += eff_w() * eff_h() + eff_w();
                end
            endcase
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
